/* rtl/ir_range_frame_decoder_defines.svh */
// assertion macros used by the checker file
`ifndef IR_RANGE_FRAME_DECODER_DEFINES_SVH
`define IR_RANGE_FRAME_DECODER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define IRFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define IRFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/irfd_pkg.sv */
// shared types and constants of the range frame decoder
package irfd_pkg;

  localparam logic [7:0] START_BYTE = 8'h69;
  localparam logic [7:0] END_BYTE   = 8'h96;

  localparam logic [15:0] MIN_CODE_RST = 16'd62;
  localparam logic [15:0] MAX_CODE_RST = 16'd531;

  localparam int ACC_W = 38;
  localparam logic signed [ACC_W-1:0] ACC_LIMIT = 38'sd68719476736;

  localparam logic [0:0] REG_MIN = 1'b0;
  localparam logic [0:0] REG_MAX = 1'b1;

  typedef enum logic [2:0] {
    PH_START,
    PH_COUNT,
    PH_LOW,
    PH_HIGH,
    PH_CALC,
    PH_END,
    PH_EMIT
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic load_low;
    logic start_calc;
    logic calc_step;
    logic store_wr;
    logic emit_load;
    logic emit_empty;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic calc_done;
    logic out_busy;
  } dp_sts_t;

  function automatic logic signed [ACC_W-1:0] poly_coef(input logic [2:0] idx);
    logic signed [ACC_W-1:0] c;
    case (idx)
      3'd0:    c = 38'sd267911;
      3'd1:    c = -38'sd2972058;
      3'd2:    c = 38'sd13677363;
      3'd3:    c = -38'sd33587200;
      3'd4:    c = 38'sd46976205;
      3'd5:    c = -38'sd36719821;
      default: c = 38'sd14254080;
    endcase
    return c;
  endfunction

endpackage

/* rtl/irfd_ctrl.sv */
// frame parsing controller
module irfd_ctrl
  import irfd_pkg::*;
#(
  parameter int MAX_SENSORS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd,
  output logic [6:0] count_q,
  output logic [6:0] pos_q
);

  phase_t     phase_r, phase_nxt;
  logic [6:0] count_r, count_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic       acc;

  assign count_q = count_r;
  assign pos_q   = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    cmd       = '0;
    in_tready = 1'b0;
    acc       = 1'b0;
    unique case (phase_r)
      PH_START: begin
        in_tready = 1'b1;
        acc = in_tvalid;
        if (acc && in_byte == START_BYTE) phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        in_tready = 1'b1;
        acc = in_tvalid;
        if (acc) begin
          if ({1'b0, in_byte} > 9'(MAX_SENSORS)) begin
            phase_nxt = PH_START;
          end else begin
            count_nxt = in_byte[6:0];
            pos_nxt   = '0;
            phase_nxt = (in_byte == 8'd0) ? PH_END : PH_LOW;
          end
        end
      end
      PH_LOW: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_low = 1'b1;
          phase_nxt = PH_HIGH;
        end
      end
      PH_HIGH: begin
        // the store may not be overwritten while the previous frame drains
        in_tready = !sts.out_busy;
        if (in_tvalid && !sts.out_busy) begin
          cmd.start_calc = 1'b1;
          phase_nxt = PH_CALC;
        end
      end
      PH_CALC: begin
        cmd.calc_step = 1'b1;
        if (sts.calc_done) begin
          cmd.store_wr = 1'b1;
          pos_nxt   = pos_r + 7'd1;
          phase_nxt = (pos_r + 7'd1 >= count_r) ? PH_END : PH_LOW;
        end
      end
      PH_END: begin
        // wait until the previous frame has fully drained
        in_tready = !sts.out_busy;
        if (in_tvalid && !sts.out_busy) begin
          if (in_byte == END_BYTE) begin
            if (count_r == 7'd0) cmd.emit_empty = 1'b1;
            else cmd.emit_load = 1'b1;
          end
          phase_nxt = PH_START;
        end
      end
      default: phase_nxt = PH_START;
    endcase
  end

endmodule

/* rtl/irfd_datapath.sv */
// code capture, horner evaluation, distance store and result output
module irfd_datapath
  import irfd_pkg::*;
#(
  parameter int MAX_SENSORS = 8,
  parameter int IDX_W = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic [15:0] min_code,
  input  logic [15:0] max_code,
  input  dp_cmd_t     cmd,
  input  logic [6:0]  count_q,
  input  logic [6:0]  pos_q,
  output dp_sts_t     sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic [7:0]  low_r;
  logic [15:0] code_r;
  logic        win_r;
  logic [2:0]  step_r;
  logic [3:0]  cyc_r;
  logic [24:0] x_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [62:0] prod_r;
  logic [41:0] xprod;
  logic [41:0] xprod_r;

  logic [16:0] store_r [MAX_SENSORS];

  logic        busy_r;
  logic [6:0]  emit_r;
  logic [6:0]  total_r;
  logic        oval_r;
  logic [5:0]  oidx_r;
  logic [15:0] odist_r;
  logic        owin_r, oempty_r, olast_r;

  logic [15:0] code_w;
  logic signed [62:0] rnd;
  logic signed [47:0] nacc;
  logic signed [ACC_W-1:0] sacc;
  logic signed [29:0] dval;
  logic [15:0] dsat;
  logic [41:0] q0, q1;
  logic [41:0] rem;

  assign code_w = {in_byte, low_r};
  assign xprod  = 42'(code_r) * 42'd327680 + 42'd511;

  // x = round(code*5*65536/1023), divide by 1023 via reciprocal and correction
  assign q0  = 42'((64'(xprod_r) * 64'd4198404) >> 32);
  assign rem = xprod_r - q0 * 42'd1023;
  assign q1  = (rem >= 42'd1023) ? q0 + 42'd1 : q0;

  // clamp at full width before narrowing to the accumulator
  assign rnd  = prod_r + 63'sd32768;
  assign nacc = 48'(rnd >>> 16) + 48'(poly_coef(step_r));
  assign sacc = (nacc > 48'(ACC_LIMIT)) ? ACC_LIMIT :
                (nacc < -48'(ACC_LIMIT)) ? -ACC_LIMIT : ACC_W'(nacc);
  assign dval = 30'((acc_r + 38'sd128) >>> 8);
  assign dsat = (dval > 30'sd32767) ? 16'h7fff :
                (dval < -30'sd32768) ? 16'h8000 : dval[15:0];

  // steps in order: load x product, divide, multiply and accumulate, store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r <= '0;
    end else if (cmd.start_calc) begin
      cyc_r <= 4'd1;
    end else if (cmd.calc_step && !sts.calc_done) begin
      cyc_r <= cyc_r + 4'd1;
    end else if (cmd.store_wr) begin
      cyc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_low) low_r <= in_byte;
    if (cmd.start_calc) begin
      code_r <= code_w;
      win_r  <= (code_w >= min_code) && (code_w <= max_code);
      step_r <= 3'd1;
      acc_r  <= poly_coef(3'd0);
    end
    if (cyc_r == 4'd1) xprod_r <= xprod;
    if (cyc_r == 4'd2) x_r <= q1[24:0];
    if (cyc_r >= 4'd3 && cmd.calc_step && !sts.calc_done) begin
      if (!cyc_r[0]) begin
        acc_r  <= sacc;
        step_r <= step_r + 3'd1;
      end else begin
        prod_r <= 63'(acc_r) * $signed({1'b0, x_r});
      end
    end
    if (cmd.store_wr && pos_q < 7'(MAX_SENSORS))
      store_r[pos_q[IDX_W-1:0]] <= {win_r, win_r ? dsat : 16'd0};
  end

  assign sts.calc_done = (cyc_r == 4'd15);
  assign sts.out_busy  = busy_r || oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
      emit_r <= '0;
      total_r <= '0;
    end else if (cmd.emit_empty) begin
      oval_r <= 1'b1;
      oidx_r <= '0; odist_r <= '0; owin_r <= 1'b0;
      oempty_r <= 1'b1; olast_r <= 1'b1;
    end else if (cmd.emit_load) begin
      busy_r  <= 1'b1;
      emit_r  <= '0;
      total_r <= count_q;
    end else if (busy_r && (!oval_r || out_tready)) begin
      oval_r   <= 1'b1;
      oidx_r   <= emit_r[5:0];
      {owin_r, odist_r} <= store_r[emit_r[IDX_W-1:0]];
      oempty_r <= 1'b0;
      olast_r  <= (emit_r + 7'd1 == total_r);
      emit_r   <= emit_r + 7'd1;
      if (emit_r + 7'd1 == total_r) busy_r <= 1'b0;
    end else if (oval_r && out_tready) begin
      oval_r <= 1'b0;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {1'b0, owin_r, odist_r, oidx_r};
  assign out_tuser  = {owin_r & 1'b0, oempty_r};
  assign out_tlast  = olast_r;

endmodule

/* rtl/ir_range_frame_decoder.sv */
// Range frame decoder: after the high byte of a code, the shared horner unit runs product
// load, divide by 1023, six multiply and accumulate steps and store write before the next
// byte is taken. After a valid end byte the stored readings leave at one result beat per
// cycle while out_tready is high; the next end byte and the next high byte of a code wait
// until they are gone.
module ir_range_frame_decoder
  import irfd_pkg::*;
#(
  parameter int MAX_SENSORS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // sensor_index[5:0], distance[21:6], in_window[22], pad
  output logic [1:0]  out_tuser,   // empty_frame[0], pad
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

  logic [15:0] min_r, max_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [6:0] count_q, pos_q;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_CODE_RST;
      max_r <= MAX_CODE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_MIN) min_r <= cfg_pwdata[15:0];
      else max_r <= cfg_pwdata[15:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX) ? {16'd0, max_r} : {16'd0, min_r};

  irfd_ctrl #(.MAX_SENSORS(MAX_SENSORS)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_byte(in_tdata),
    .sts, .cmd, .count_q, .pos_q
  );

  irfd_datapath #(.MAX_SENSORS(MAX_SENSORS), .IDX_W(IDX_W)) u_dp (
    .clk, .rst_n, .in_byte(in_tdata), .min_code(min_r), .max_code(max_r),
    .cmd, .count_q, .pos_q, .sts,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule

/* rtl/irfd_checker.sv */
// port level checks of the range frame decoder
`include "ir_range_frame_decoder_defines.svh"
module irfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_pready
);
  `IRFD_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `IRFD_ASSERT(a_empty_last, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tlast, "empty not last")
  `IRFD_ASSERT(a_win_zero, clk, rst_n, out_tvalid && !out_tdata[22] |-> out_tdata[21:6] == 16'd0, "distance outside window")
  `IRFD_ASSERT_ALWAYS(a_ready, clk, cfg_pready, "pready low")
endmodule

bind ir_range_frame_decoder irfd_checker u_chk (.*);
